// File: rtl/core/blm_pkg.sv
// ----------------------------------------------------------------------------
// blm_pkg
// shared types, constants and saturating fixed-point helpers for the
// brent line minimizer
// ----------------------------------------------------------------------------
package blm_pkg;

   localparam int FRAC_BITS = 32;
   localparam int CSR_IDX_W = 8;

   localparam logic signed [63:0] FIX_ONE  = 64'sh1 << FRAC_BITS;
   localparam logic signed [63:0] FIX_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] FIX_MIN  = 64'sh8000_0000_0000_0000;
   localparam logic [63:0]        CG_FRAC  = 64'h61C8_8646_80B5_83EA;
   localparam logic [63:0]        REL_FRAC = 64'h0000_002A_F31D_C461;

   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_REPLY = 2'd1;
   localparam logic [1:0] ACT_ABORT = 2'd2;

   localparam logic KIND_EVAL = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_TOLERANCE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_ITER  = 8'd1;

   typedef struct packed {
      logic              go;
      logic signed [63:0] a;
      logic [63:0]        b;
      logic              frac;
      logic              half;
   } mul_req_type;

   typedef struct packed {
      logic              done;
      logic signed [63:0] res;
   } mul_rsp_type;

   typedef struct packed {
      logic              go;
      logic signed [63:0] p;
      logic signed [63:0] q;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic signed [63:0] quot;
   } div_rsp_type;

   function automatic logic [63:0] mag(input logic signed [63:0] v);
      return v[63] ? (64'd0 - v) : v;
   endfunction

   function automatic logic signed [63:0] from_mag(input logic [63:0] m, input logic neg);
      if (neg) begin
         if (m[63]) return FIX_MIN;
         return 64'sd0 - $signed(m);
      end
      if (m[63]) return FIX_MAX;
      return $signed(m);
   endfunction

   function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? FIX_MIN : FIX_MAX;
      return $signed(s[63:0]);
   endfunction

   function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
      logic [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) return s[64] ? FIX_MIN : FIX_MAX;
      return $signed(s[63:0]);
   endfunction

   function automatic logic signed [63:0] sneg(input logic signed [63:0] a);
      return (a == FIX_MIN) ? FIX_MAX : (64'sd0 - a);
   endfunction

   function automatic logic signed [63:0] sabs(input logic signed [63:0] a);
      return a[63] ? sneg(a) : a;
   endfunction

   function automatic logic signed [63:0] floor_avg(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic [63:0] x;
      logic [63:0] s;
      x = a ^ b;
      s = {x[63], x[63:1]};
      return $signed((a & b) + s);
   endfunction

endpackage

// File: rtl/core/blm_if.sv
// ----------------------------------------------------------------------------
// blm channel interfaces
// request, response and csr write channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface blm_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        action;
   logic signed [63:0] bracket_low;
   logic signed [63:0] bracket_mid;
   logic signed [63:0] bracket_high;
   logic signed [63:0] start_value;
   logic signed [63:0] func_value;
   modport source (output valid, action, bracket_low, bracket_mid, bracket_high,
                   start_value, func_value, input ready);
   modport sink   (input valid, action, bracket_low, bracket_mid, bracket_high,
                   start_value, func_value, output ready);
endinterface

interface blm_rsp_if;
   logic              valid;
   logic              ready;
   logic              kind;
   logic signed [63:0] position;
   logic signed [63:0] best_value;
   logic [15:0]       iterations_used;
   modport source (output valid, kind, position, best_value, iterations_used,
                   input ready);
   modport sink   (input valid, kind, position, best_value, iterations_used,
                   output ready);
endinterface

interface blm_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/brent_line_minimizer.sv
// ----------------------------------------------------------------------------
// brent_line_minimizer
// brent line search sequencer driving an outside objective evaluator
// steps: a parabolic step runs eight multiplies on the shared multiplier plus
//   the divide; a rejected parabolic step takes the golden-section step instead
// throughput: one transaction per step, req not ready while a step runs
// reset: synchronous, idle, control and search registers back to their defaults
// ----------------------------------------------------------------------------
module brent_line_minimizer import blm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   blm_csr_if.sink   csr_ch,
   blm_req_if.sink   req_ch,
   blm_rsp_if.source rsp_ch
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_WAITR = 5'd1;
   localparam logic [4:0] S_ADV   = 5'd2;
   localparam logic [4:0] S_REL   = 5'd3;
   localparam logic [4:0] S_TOL   = 5'd4;
   localparam logic [4:0] S_CHK   = 5'd5;
   localparam logic [4:0] S_GOLD  = 5'd6;
   localparam logic [4:0] S_R     = 5'd7;
   localparam logic [4:0] S_Q     = 5'd8;
   localparam logic [4:0] S_P1    = 5'd9;
   localparam logic [4:0] S_P2    = 5'd10;
   localparam logic [4:0] S_PQ    = 5'd11;
   localparam logic [4:0] S_C1    = 5'd12;
   localparam logic [4:0] S_C2    = 5'd13;
   localparam logic [4:0] S_C3    = 5'd14;
   localparam logic [4:0] S_DEC   = 5'd15;
   localparam logic [4:0] S_DIV   = 5'd16;
   localparam logic [4:0] S_UCHK  = 5'd17;
   localparam logic [4:0] S_FINAL = 5'd18;
   localparam logic [4:0] S_FIN   = 5'd19;

   logic [4:0]  state_ff, state_in;
   logic [32:0] tol_ff, tol_in;
   logic [15:0] maxit_ff, maxit_in;
   logic        wait_ff, wait_in;
   logic [15:0] iter_ff, iter_in;
   logic signed [63:0] low_ff, low_in, high_ff, high_in;
   logic signed [63:0] x_ff, x_in, w_ff, w_in, v_ff, v_in;
   logic signed [63:0] fx_ff, fx_in, fw_ff, fw_in, fv_ff, fv_in;
   logic signed [63:0] prev_ff, prev_in, last_ff, last_in, pend_ff, pend_in;
   logic signed [63:0] xc_ff, xc_in, tol1_ff, tol1_in, tol2_ff, tol2_in;
   logic signed [63:0] r_ff, r_in, q_ff, q_in, p_ff, p_in, etmp_ff, etmp_in;
   logic signed [63:0] c1_ff, c1_in, c2_ff, c2_in, c3_ff, c3_in;
   logic        rsp_valid_ff, rsp_valid_in, rsp_kind_ff, rsp_kind_in;
   logic signed [63:0] rsp_pos_ff, rsp_pos_in, rsp_best_ff, rsp_best_in;
   logic [15:0] rsp_iter_ff, rsp_iter_in;

   mul_req_type mul_req;
   mul_rsp_type mul_rsp;
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic        accept, out_free, mul_fin;
   logic signed [63:0] ea, eb, fu, hw, t, q2, u, d, sel;
   logic [63:0] span;

   blm_mul u_mul (.clock(clock), .reset(reset), .req(mul_req), .rsp(mul_rsp));
   blm_div u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));

   assign req_ch.ready = (state_ff == S_IDLE) || (state_ff == S_WAITR);
   assign csr_ch.ready = 1'b1;
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign mul_fin      = wait_ff && mul_rsp.done;

   // shared multiplier operand select
   always_comb begin
      mul_req.go   = 1'b0;
      mul_req.frac = 1'b0;
      mul_req.half = 1'b0;
      mul_req.a    = q_ff;
      mul_req.b    = etmp_ff;
      unique case (state_ff)
         S_REL: begin
            mul_req.a = sabs(x_ff); mul_req.b = REL_FRAC; mul_req.frac = 1'b1;
         end
         S_GOLD: begin
            mul_req.a = prev_ff; mul_req.b = CG_FRAC; mul_req.frac = 1'b1;
         end
         S_R:  begin mul_req.a = ssub(x_ff, w_ff); mul_req.b = ssub(fx_ff, fv_ff); end
         S_Q:  begin mul_req.a = ssub(x_ff, v_ff); mul_req.b = ssub(fx_ff, fw_ff); end
         S_P1: begin mul_req.a = ssub(x_ff, v_ff); mul_req.b = q_ff; end
         S_P2: begin mul_req.a = ssub(x_ff, w_ff); mul_req.b = r_ff; end
         S_C1: mul_req.b = ssub(low_ff, x_ff);
         S_C2: mul_req.b = ssub(high_ff, x_ff);
         S_C3: mul_req.half = 1'b1;
         default: ;
      endcase
      if ((state_ff == S_REL || state_ff == S_GOLD || state_ff == S_R || state_ff == S_Q ||
           state_ff == S_P1 || state_ff == S_P2 || state_ff == S_C1 || state_ff == S_C2 ||
           state_ff == S_C3) && !wait_ff)
         mul_req.go = 1'b1;
      div_req.go = (state_ff == S_DIV) && !wait_ff;
      div_req.p  = p_ff;
      div_req.q  = q_ff;
   end

   always_comb begin
      state_in = state_ff;  tol_in = tol_ff;  maxit_in = maxit_ff;  wait_in = wait_ff;
      iter_in = iter_ff;  low_in = low_ff;  high_in = high_ff;
      x_in = x_ff;  w_in = w_ff;  v_in = v_ff;  fx_in = fx_ff;  fw_in = fw_ff;  fv_in = fv_ff;
      prev_in = prev_ff;  last_in = last_ff;  pend_in = pend_ff;
      xc_in = xc_ff;  tol1_in = tol1_ff;  tol2_in = tol2_ff;
      r_in = r_ff;  q_in = q_ff;  p_in = p_ff;  etmp_in = etmp_ff;
      c1_in = c1_ff;  c2_in = c2_ff;  c3_in = c3_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in = rsp_kind_ff;  rsp_pos_in = rsp_pos_ff;
      rsp_best_in = rsp_best_ff;  rsp_iter_in = rsp_iter_ff;
      ea   = req_ch.bracket_low;
      eb   = req_ch.bracket_high;
      fu   = req_ch.func_value;
      span = high_ff - low_ff;
      hw   = $signed({1'b0, span[63:1]});
      sel  = (x_ff < xc_ff) ? high_ff : low_ff;
      t    = ssub(q_ff, r_ff);
      q2   = sadd(t, t);
      d    = last_ff;
      u    = sadd(x_ff, last_ff);

      if (csr_ch.valid) begin
         if (csr_ch.index == REG_TOLERANCE) tol_in = csr_ch.data[32:0];
         else if (csr_ch.index == REG_MAX_ITER) maxit_in = csr_ch.data[15:0];
      end

      unique case (state_ff)
         S_IDLE, S_WAITR: begin
            if (accept) begin
               if (req_ch.action == ACT_START) begin
                  if (ea > eb) begin
                     low_in = eb; high_in = ea;
                  end else begin
                     low_in = ea; high_in = eb;
                  end
                  x_in = req_ch.bracket_mid; w_in = req_ch.bracket_mid;
                  v_in = req_ch.bracket_mid;
                  fx_in = req_ch.start_value; fw_in = req_ch.start_value;
                  fv_in = req_ch.start_value;
                  prev_in = 64'sd0; last_in = FIX_ONE; pend_in = 64'sd0;
                  iter_in = 16'd0;
                  state_in = S_ADV;
               end else if (state_ff == S_WAITR && req_ch.action == ACT_REPLY) begin
                  if (iter_ff != 16'hFFFF) iter_in = iter_ff + 16'd1;
                  if (fu > fx_ff) begin
                     if (pend_ff < x_ff) low_in = pend_ff;
                     else high_in = pend_ff;
                     if (fu <= fw_ff || w_ff == x_ff) begin
                        v_in = w_ff; fv_in = fw_ff; w_in = pend_ff; fw_in = fu;
                     end else if (fu <= fv_ff || v_ff == x_ff || v_ff == w_ff) begin
                        v_in = pend_ff; fv_in = fu;
                     end
                  end else begin
                     if (pend_ff >= x_ff) low_in = x_ff;
                     else high_in = x_ff;
                     v_in = w_ff; fv_in = fw_ff; w_in = x_ff; fw_in = fx_ff;
                     x_in = pend_ff; fx_in = fu;
                  end
                  state_in = S_ADV;
               end else if (state_ff == S_WAITR && req_ch.action == ACT_ABORT) begin
                  state_in = S_FIN;
               end
            end
         end
         S_ADV: begin
            if (iter_ff >= maxit_ff) state_in = S_FIN;
            else begin
               xc_in = floor_avg(low_ff, high_ff);
               state_in = S_REL;
            end
         end
         S_REL, S_GOLD, S_R, S_Q, S_P1, S_P2, S_C1, S_C2, S_C3: begin
            if (!wait_ff) wait_in = 1'b1;
            else if (mul_fin) begin
               wait_in = 1'b0;
               unique case (state_ff)
                  S_REL: begin
                     tol1_in = sadd($signed({31'd0, tol_ff}), mul_rsp.res); state_in = S_TOL;
                  end
                  S_GOLD: begin last_in = mul_rsp.res; state_in = S_FINAL; end
                  S_R:  begin r_in = mul_rsp.res; state_in = S_Q; end
                  S_Q:  begin q_in = mul_rsp.res; state_in = S_P1; end
                  S_P1: begin p_in = mul_rsp.res; state_in = S_P2; end
                  S_P2: begin p_in = sadd(p_ff, mul_rsp.res); state_in = S_PQ; end
                  S_C1: begin c1_in = mul_rsp.res; state_in = S_C2; end
                  S_C2: begin c2_in = mul_rsp.res; state_in = S_C3; end
                  default: begin c3_in = mul_rsp.res; state_in = S_DEC; end
               endcase
            end
         end
         S_TOL: begin
            tol2_in = sadd(tol1_ff, tol1_ff);
            state_in = S_CHK;
         end
         S_CHK: begin
            if (sabs(ssub(x_ff, xc_ff)) < ssub(tol2_ff, hw)) state_in = S_FIN;
            else if (sabs(prev_ff) <= tol1_ff) begin
               prev_in = ssub(sel, x_ff);
               state_in = S_GOLD;
            end else state_in = S_R;
         end
         S_PQ: begin
            if (q2 > 64'sd0) p_in = sneg(p_ff);
            q_in = sabs(q2);
            etmp_in = prev_ff;
            prev_in = last_ff;
            state_in = S_C1;
         end
         S_DEC: begin
            if (p_ff > c1_ff && p_ff < c2_ff && sabs(p_ff) < sabs(c3_ff)) state_in = S_DIV;
            else begin
               prev_in = ssub(sel, x_ff);
               state_in = S_GOLD;
            end
         end
         S_DIV: begin
            if (!wait_ff) wait_in = 1'b1;
            else if (div_rsp.done) begin
               wait_in = 1'b0;
               last_in = div_rsp.quot;
               state_in = S_UCHK;
            end
         end
         S_UCHK: begin
            if (ssub(u, low_ff) < tol2_ff || ssub(high_ff, u) < tol2_ff)
               last_in = (xc_ff < x_ff) ? sneg(tol1_ff) : tol1_ff;
            state_in = S_FINAL;
         end
         S_FINAL: begin
            if (out_free) begin
               if (sabs(d) < tol1_ff) u = sadd(x_ff, d[63] ? sneg(tol1_ff) : tol1_ff);
               pend_in = u;
               rsp_valid_in = 1'b1; rsp_kind_in = KIND_EVAL; rsp_pos_in = u;
               rsp_best_in = fx_ff; rsp_iter_in = iter_ff;
               state_in = S_WAITR;
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1; rsp_kind_in = KIND_DONE; rsp_pos_in = x_ff;
               rsp_best_in = fx_ff; rsp_iter_in = iter_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tol_ff       <= 33'd4295;
         maxit_ff     <= 16'd100;
         wait_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         iter_ff      <= 16'd0;
         low_ff  <= 64'sd0;  high_ff <= 64'sd0;
         x_ff    <= 64'sd0;  w_ff    <= 64'sd0;  v_ff  <= 64'sd0;
         fx_ff   <= 64'sd0;  fw_ff   <= 64'sd0;  fv_ff <= 64'sd0;
         prev_ff <= 64'sd0;  last_ff <= FIX_ONE; pend_ff <= 64'sd0;
      end else begin
         state_ff     <= state_in;
         tol_ff       <= tol_in;
         maxit_ff     <= maxit_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
         iter_ff      <= iter_in;
         low_ff  <= low_in;   high_ff <= high_in;
         x_ff    <= x_in;     w_ff    <= w_in;    v_ff  <= v_in;
         fx_ff   <= fx_in;    fw_ff   <= fw_in;   fv_ff <= fv_in;
         prev_ff <= prev_in;  last_ff <= last_in; pend_ff <= pend_in;
      end
      xc_ff <= xc_in;  tol1_ff <= tol1_in;  tol2_ff <= tol2_in;
      r_ff  <= r_in;   q_ff <= q_in;  p_ff <= p_in;  etmp_ff <= etmp_in;
      c1_ff <= c1_in;  c2_ff <= c2_in;  c3_ff <= c3_in;
      rsp_kind_ff <= rsp_kind_in;  rsp_pos_ff <= rsp_pos_in;
      rsp_best_ff <= rsp_best_in;  rsp_iter_ff <= rsp_iter_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.kind            = rsp_kind_ff;
   assign rsp_ch.position        = rsp_pos_ff;
   assign rsp_ch.best_value      = rsp_best_ff;
   assign rsp_ch.iterations_used = rsp_iter_ff;

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.action == ACT_START |=> iter_ff == 16'd0 && state_ff == S_ADV)
      else $error("start transaction did not restart the search");

   a_mul_owned: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> wait_ff)
      else $error("multiplier result with no step waiting on it");

   a_iter_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_in && !rsp_valid_ff && rsp_kind_in == KIND_EVAL |-> iter_ff < maxit_ff)
      else $error("evaluate request issued past the iteration cap");

endmodule

// File: rtl/core/blm_mul.sv
// ----------------------------------------------------------------------------
// blm_mul
// shared saturating fixed-point multiplier, one 32x32 partial product
// per cycle
// ----------------------------------------------------------------------------
module blm_mul import blm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);

   localparam logic [1:0] SH_Q    = 2'd0;
   localparam logic [1:0] SH_HALF = 2'd1;
   localparam logic [1:0] SH_HI   = 2'd2;

   logic              busy_ff, busy_in;
   logic [2:0]        step_ff, step_in;
   logic [63:0]       am_ff, am_in, bm_ff, bm_in;
   logic              neg_ff, neg_in;
   logic [1:0]        sh_ff, sh_in;
   logic [127:0]      acc_ff, acc_in;
   logic              done_ff, done_in;
   logic signed [63:0] res_ff, res_in;

   logic [63:0]  pp;
   logic [127:0] pp_sh;
   logic [127:0] shifted;

   assign pp = {32'd0, am_ff[step_ff[1]*32 +: 32]} * {32'd0, bm_ff[step_ff[0]*32 +: 32]};

   always_comb begin
      unique case (step_ff[1:0])
         2'd0:       pp_sh = {64'd0, pp};
         2'd1, 2'd2: pp_sh = {32'd0, pp, 32'd0};
         2'd3:       pp_sh = {pp, 64'd0};
      endcase
      unique case (sh_ff)
         SH_HALF: shifted = acc_ff >> (FRAC_BITS + 1);
         SH_HI:   shifted = acc_ff >> 64;
         default: shifted = acc_ff >> FRAC_BITS;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      am_in   = am_ff;
      bm_in   = bm_ff;
      neg_in  = neg_ff;
      sh_in   = sh_ff;
      acc_in  = acc_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      if (req.go) begin
         busy_in = 1'b1;
         step_in = 3'd0;
         am_in   = mag(req.a);
         bm_in   = req.frac ? req.b : mag($signed(req.b));
         neg_in  = req.a[63] ^ (!req.frac & req.b[63]);
         sh_in   = req.frac ? SH_HI : (req.half ? SH_HALF : SH_Q);
         acc_in  = 128'd0;
      end else if (busy_ff) begin
         if (step_ff[2]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = from_mag((|shifted[127:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : shifted[63:0],
                               neg_ff);
         end else begin
            acc_in  = acc_ff + pp_sh;
            step_in = step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      am_ff  <= am_in;
      bm_ff  <= bm_in;
      neg_ff <= neg_in;
      sh_ff  <= sh_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
   end

   assign rsp.done = done_ff;
   assign rsp.res  = res_ff;

endmodule

// File: rtl/core/blm_div.sv
// ----------------------------------------------------------------------------
// blm_div
// fixed-point restoring divider, one quotient bit per cycle, saturating
// ----------------------------------------------------------------------------
module blm_div import blm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic              busy_ff, busy_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [63:0]       r_ff, r_in, lo_ff, lo_in, d_ff, d_in, quo_ff, quo_in;
   logic              neg_ff, neg_in;
   logic              done_ff, done_in;
   logic signed [63:0] quot_ff, quot_in;

   logic [63:0] n, dm, hi, rs, quo_sh;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      lo_in   = lo_ff;
      d_in    = d_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      quot_in = quot_ff;
      n       = mag(req.p);
      dm      = mag(req.q);
      hi      = n >> (64 - FRAC_BITS);
      rs      = {r_ff[62:0], lo_ff[63]};
      quo_sh  = {quo_ff[62:0], 1'b0};
      if (req.go) begin
         neg_in = req.p[63] ^ req.q[63];
         if (dm == 64'd0) begin
            done_in = 1'b1;
            quot_in = (req.p == 64'sd0) ? 64'sd0 : (req.p[63] ? FIX_MIN : FIX_MAX);
         end else if (hi >= dm) begin
            done_in = 1'b1;
            quot_in = from_mag(64'hFFFF_FFFF_FFFF_FFFF, req.p[63] ^ req.q[63]);
         end else begin
            busy_in = 1'b1;
            cnt_in  = 6'd63;
            r_in    = hi;
            lo_in   = n << FRAC_BITS;
            d_in    = dm;
            quo_in  = 64'd0;
         end
      end else if (busy_ff) begin
         lo_in = {lo_ff[62:0], 1'b0};
         if (r_ff[63] || rs >= d_ff) begin
            r_in   = rs - d_ff;
            quo_in = quo_sh | 64'd1;
         end else begin
            r_in   = rs;
            quo_in = quo_sh;
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            quot_in = from_mag(quo_in, neg_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      r_ff    <= r_in;
      lo_ff   <= lo_in;
      d_ff    <= d_in;
      quo_ff  <= quo_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// brent line minimizer testbench
// drives line searches against quadratic objectives with random noise,
// predicts every evaluate request and finish result, and checks each
// response transaction against the expected one, field by field
// ----------------------------------------------------------------------------
module testbench;
   import blm_pkg::*;

   typedef logic signed [63:0] fix_type;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam fix_type    MOST_NEG   = 64'sh8000_0000_0000_0000;
   localparam fix_type    MOST_POS   = 64'sh7FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic        kind;
      fix_type     position;
      fix_type     best_value;
      logic [15:0] iterations_used;
   } search_result_type;

   logic clock;
   logic reset;
   logic calm;
   int   items_sent;

   blm_csr_if csr_ch();
   blm_req_if req_ch();
   blm_rsp_if rsp_ch();

   brent_line_minimizer dut (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   function automatic fix_type clamp_add(fix_type a, fix_type b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? MOST_NEG : MOST_POS;
      return s[63:0];
   endfunction

   function automatic fix_type clamp_sub(fix_type a, fix_type b);
      logic [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) return s[64] ? MOST_NEG : MOST_POS;
      return s[63:0];
   endfunction

   function automatic fix_type clamp_neg(fix_type a);
      return (a == MOST_NEG) ? MOST_POS : -a;
   endfunction

   function automatic fix_type clamp_abs(fix_type a);
      return a[63] ? clamp_neg(a) : a;
   endfunction

   function automatic logic [63:0] magnitude(fix_type v);
      return v[63] ? (64'd0 - v) : v;
   endfunction

   function automatic fix_type signed_from(logic [63:0] m, logic neg);
      if (neg) return m[63] ? MOST_NEG : fix_type'(64'd0 - m);
      return m[63] ? MOST_POS : fix_type'(m);
   endfunction

   function automatic fix_type fix_mul_shift(fix_type a, fix_type b, int sh);
      logic [127:0] prod;
      logic [63:0]  m;
      prod = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
      prod = prod >> sh;
      m = (prod[127:64] != 0) ? '1 : prod[63:0];
      return signed_from(m, a[63] != b[63]);
   endfunction

   function automatic fix_type fix_mul_frac(fix_type a, logic [63:0] c);
      logic [127:0] prod;
      prod = {64'd0, magnitude(a)} * {64'd0, c};
      return signed_from(prod[127:64], a[63]);
   endfunction

   function automatic fix_type fix_div(fix_type p, fix_type q);
      logic [127:0] num;
      logic [127:0] quo;
      logic [63:0]  d;
      logic         neg;
      neg = p[63] != q[63];
      if (q == 0) return (p == 0) ? 64'sd0 : (p[63] ? MOST_NEG : MOST_POS);
      d = magnitude(q);
      num = {64'd0, magnitude(p)} << FRAC_BITS;
      if (num[127:64] >= d) return signed_from('1, neg);
      quo = num / {64'd0, d};
      return signed_from(quo[63:0], neg);
   endfunction

   function automatic fix_type mid_floor(fix_type a, fix_type b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      s = s >>> 1;
      return s[63:0];
   endfunction

   class minimizer_scoreboard;
      logic [32:0]       tolerance;
      logic [15:0]       max_iterations;
      fix_type           low_end, high_end;
      fix_type           best_pos, second_pos, third_pos;
      fix_type           best_val, second_val, third_val;
      fix_type           prev_step, last_step, pending_pos;
      logic [15:0]       iter_count;
      bit                busy;
      search_result_type expected_q[$];
      int                mismatches;

      function new();
         tolerance = 33'd4295;
         max_iterations = 16'd100;
         low_end = 0; high_end = 0;
         best_pos = 0; second_pos = 0; third_pos = 0;
         best_val = 0; second_val = 0; third_val = 0;
         prev_step = 0; last_step = FIX_ONE; pending_pos = 0;
         iter_count = 0; busy = 0; mismatches = 0;
      endfunction

      function void set_reg(logic [7:0] idx, logic [63:0] data);
         if (idx == REG_TOLERANCE) tolerance = data[32:0];
         else if (idx == REG_MAX_ITER) max_iterations = data[15:0];
      endfunction

      function void push_result(logic kind, fix_type pos);
         search_result_type r;
         r.kind = kind;
         r.position = pos;
         r.best_value = best_val;
         r.iterations_used = iter_count;
         expected_q.push_back(r);
      endfunction

      function void finish_search();
         busy = 0;
         push_result(KIND_DONE, best_pos);
      endfunction

      function void golden_step(fix_type x, fix_type xc);
         prev_step = clamp_sub((x < xc) ? high_end : low_end, x);
         last_step = fix_mul_frac(prev_step, CG_FRAC);
      endfunction

      function void next_position();
         fix_type x, xc, tol1, tol2, half_w, r, q, p, t, etmp, u, d;
         logic [63:0] w;
         x = best_pos;
         if (iter_count >= max_iterations) begin
            finish_search();
            return;
         end
         tol1 = clamp_add(fix_type'({31'd0, tolerance}), fix_mul_frac(clamp_abs(x), REL_FRAC));
         tol2 = clamp_add(tol1, tol1);
         xc = mid_floor(low_end, high_end);
         w = (high_end - low_end) >> 1;
         half_w = w;
         if (clamp_abs(clamp_sub(x, xc)) < clamp_sub(tol2, half_w)) begin
            finish_search();
            return;
         end
         if (clamp_abs(prev_step) <= tol1) begin
            golden_step(x, xc);
         end else begin
            r = fix_mul_shift(clamp_sub(x, second_pos), clamp_sub(best_val, third_val), FRAC_BITS);
            q = fix_mul_shift(clamp_sub(x, third_pos), clamp_sub(best_val, second_val), FRAC_BITS);
            p = clamp_add(fix_mul_shift(clamp_sub(x, third_pos), q, FRAC_BITS),
                          fix_mul_shift(clamp_sub(x, second_pos), r, FRAC_BITS));
            t = clamp_sub(q, r);
            etmp = prev_step;
            q = clamp_add(t, t);
            if (q > 0) p = clamp_neg(p);
            q = clamp_abs(q);
            prev_step = last_step;
            if (p > fix_mul_shift(q, clamp_sub(low_end, x), FRAC_BITS) &&
                p < fix_mul_shift(q, clamp_sub(high_end, x), FRAC_BITS) &&
                clamp_abs(p) < clamp_abs(fix_mul_shift(q, etmp, FRAC_BITS + 1))) begin
               last_step = fix_div(p, q);
               u = clamp_add(x, last_step);
               if (clamp_sub(u, low_end) < tol2 || clamp_sub(high_end, u) < tol2)
                  last_step = (xc < x) ? clamp_neg(tol1) : tol1;
            end else begin
               golden_step(x, xc);
            end
         end
         d = last_step;
         u = clamp_add(x, d);
         if (clamp_abs(d) < tol1) u = clamp_add(x, (d < 0) ? clamp_neg(tol1) : tol1);
         pending_pos = u;
         push_result(KIND_EVAL, u);
      endfunction

      function void absorb_value(fix_type fu);
         fix_type u;
         u = pending_pos;
         if (iter_count != 16'hFFFF) iter_count++;
         if (fu > best_val) begin
            if (u < best_pos) low_end = u;
            else high_end = u;
            if (fu <= second_val || second_pos == best_pos) begin
               third_pos = second_pos; third_val = second_val;
               second_pos = u; second_val = fu;
            end else if (fu <= third_val || third_pos == best_pos ||
                         third_pos == second_pos) begin
               third_pos = u; third_val = fu;
            end
         end else begin
            if (u >= best_pos) low_end = best_pos;
            else high_end = best_pos;
            third_pos = second_pos; third_val = second_val;
            second_pos = best_pos; second_val = best_val;
            best_pos = u; best_val = fu;
         end
      endfunction

      function void note_request(logic [1:0] act, fix_type lo, fix_type mid, fix_type hi,
                                 fix_type sv, fix_type fv);
         if (act == ACT_START) begin
            low_end = (lo > hi) ? hi : lo;
            high_end = (lo > hi) ? lo : hi;
            best_pos = mid; second_pos = mid; third_pos = mid;
            best_val = sv; second_val = sv; third_val = sv;
            prev_step = 0; last_step = FIX_ONE; pending_pos = 0;
            iter_count = 0; busy = 1;
            next_position();
         end else if (busy && act == ACT_REPLY) begin
            absorb_value(fv);
            next_position();
         end else if (busy && act == ACT_ABORT) begin
            finish_search();
         end
      endfunction

      function void check_result(search_result_type got);
         search_result_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: kind %0d pos %0d best %0d iters %0d",
                        got.kind, got.position, got.best_value, got.iterations_used);
            return;
         end
         want = expected_q.pop_front();
         if (got.kind != want.kind || got.position != want.position ||
             got.best_value != want.best_value ||
             got.iterations_used != want.iterations_used) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected kind %0d pos %0d best %0d iters %0d, ",
                        want.kind, want.position, want.best_value, want.iterations_used,
                        "got kind %0d pos %0d best %0d iters %0d",
                        got.kind, got.position, got.best_value, got.iterations_used);
         end
      endfunction
   endclass

   minimizer_scoreboard sb;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      rsp_ch.ready = 0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= calm || ($urandom_range(99) >= 33);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_result({rsp_ch.kind, rsp_ch.position, rsp_ch.best_value,
                          rsp_ch.iterations_used});
   end

   function automatic fix_type rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_item(logic [1:0] act, fix_type lo, fix_type mid, fix_type hi,
                            fix_type sv, fix_type fv);
      if (!calm)
         while ($urandom_range(99) < 33) @(negedge clock);
      req_ch.action = act;
      req_ch.bracket_low = lo;
      req_ch.bracket_mid = mid;
      req_ch.bracket_high = hi;
      req_ch.start_value = sv;
      req_ch.func_value = fv;
      req_ch.valid = 1;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      sb.note_request(act, lo, mid, hi, sv, fv);
      items_sent++;
      calm = (items_sent >= 500 && items_sent < 700);
      @(negedge clock);
      req_ch.valid = 0;
   endtask

   task automatic wait_drained();
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(logic [7:0] idx, logic [63:0] data);
      @(negedge clock);
      csr_ch.index = idx;
      csr_ch.data = data;
      csr_ch.valid = 1;
      do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
      sb.set_reg(idx, data);
      @(negedge clock);
      csr_ch.valid = 0;
   endtask

   // quadratic bowl around center, curvature set by shift
   function automatic fix_type bowl(fix_type u, fix_type center, int sh, fix_type offset);
      fix_type d;
      d = clamp_sub(u, center);
      return clamp_add(fix_mul_shift(d, d, sh), offset);
   endfunction

   task automatic run_search(int len);
      fix_type center, scale, lo, mid, hi, offset, sv;
      int      sh, n, r;
      bit      noisy;
      noisy = ($urandom_range(99) < 10);
      center = fix_type'($signed($urandom)) <<< $urandom_range(0, 24);
      scale = 64'sd1 <<< $urandom_range(8, 44);
      sh = $urandom_range(20, 44);
      offset = fix_type'($signed($urandom)) <<< $urandom_range(0, 30);
      lo = clamp_sub(center, scale * $urandom_range(1, 3));
      hi = clamp_add(center, scale * $urandom_range(1, 3));
      mid = clamp_add(center, fix_type'($signed($urandom)) % (scale >>> 1));
      if ($urandom_range(1)) begin
         sv = lo; lo = hi; hi = sv;
      end
      sv = bowl(mid, center, sh, offset);
      if (noisy) begin
         lo = rand64(); mid = rand64(); hi = rand64(); sv = rand64();
      end
      send_item(ACT_START, lo, mid, hi, sv, rand64());
      n = 0;
      while (sb.busy && n < len) begin
         r = $urandom_range(99);
         if (r < 3)
            send_item(ACT_ABORT, rand64(), rand64(), rand64(), rand64(), rand64());
         else if (r < 5)
            send_item(ACT_START, lo, mid, hi, sv, rand64());
         else if (r < 7)
            send_item(ACT_UNUSED, rand64(), rand64(), rand64(), rand64(), rand64());
         else if (r < 10 || noisy)
            send_item(ACT_REPLY, rand64(), rand64(), rand64(), rand64(), rand64());
         else
            send_item(ACT_REPLY, rand64(), rand64(), rand64(), rand64(),
                      bowl(sb.pending_pos, center, sh, offset));
         n++;
      end
      if (sb.busy)
         send_item(ACT_ABORT, rand64(), rand64(), rand64(), rand64(), rand64());
      if ($urandom_range(99) < 5)
         send_item(ACT_REPLY, rand64(), rand64(), rand64(), rand64(), rand64());
   endtask

   initial begin
      logic [32:0] tol_set [5];
      logic [15:0] iter_set [5];
      bit          paused;
      sb = new();
      calm = 0;
      items_sent = 0;
      paused = 0;
      reset = 1;
      req_ch.valid = 0;
      req_ch.action = ACT_START;
      req_ch.bracket_low = 0;
      req_ch.bracket_mid = 0;
      req_ch.bracket_high = 0;
      req_ch.start_value = 0;
      req_ch.func_value = 0;
      csr_ch.valid = 0;
      csr_ch.index = REG_TOLERANCE;
      csr_ch.data = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed corners with reset register values
      send_item(ACT_REPLY, 0, 0, 0, 0, MOST_POS);
      send_item(ACT_ABORT, 0, 0, 0, 0, 0);
      send_item(ACT_UNUSED, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG);
      send_item(ACT_START, MOST_NEG, 0, MOST_POS, MOST_POS, 0);
      send_item(ACT_REPLY, 0, 0, 0, 0, MOST_NEG);
      send_item(ACT_REPLY, 0, 0, 0, 0, MOST_POS);
      send_item(ACT_REPLY, 0, 0, 0, 0, 0);
      send_item(ACT_UNUSED, MOST_POS, MOST_POS, MOST_POS, MOST_POS, MOST_POS);
      send_item(ACT_START, MOST_POS, -64'sd1, MOST_NEG, MOST_NEG, 0);
      send_item(ACT_REPLY, -1, -1, -1, -1, -1);
      send_item(ACT_ABORT, 0, 0, 0, 0, 0);
      send_item(ACT_START, 64'sd3 <<< 32, 64'sd1 <<< 32, -(64'sd2 <<< 32), 0, 0);
      send_item(ACT_REPLY, 0, 0, 0, 0, 64'sd1 <<< 32);
      send_item(ACT_REPLY, 0, 0, 0, 0, 64'sd5);
      send_item(ACT_ABORT, 0, 0, 0, 0, 0);
      send_item(ACT_START, 5, 5, 5, 0, 0);
      if (sb.busy) send_item(ACT_ABORT, 0, 0, 0, 0, 0);

      tol_set  = '{33'd0, 33'h1_0000_0000, 33'd0, 33'd4295, 33'd4295};
      iter_set = '{16'd0, 16'd1, 16'hFFFF, 16'd100, 16'd100};
      tol_set[3] = 33'({$urandom_range(1), $urandom});
      iter_set[3] = 16'($urandom_range(2, 200));
      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) begin
            wait_drained();
            write_reg(REG_TOLERANCE, {31'd0, tol_set[ph-1]}
                      | ({$urandom, $urandom} & 64'hFFFF_FFFE_0000_0000));
            write_reg(REG_MAX_ITER, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_0000
                      | {48'd0, iter_set[ph-1]});
         end
         while (items_sent < 17 + (ph + 1) * 256) begin
            run_search($urandom_range(1, 60));
            if (!paused && items_sent > 300) begin
               send_item(ACT_START, -(64'sd1 <<< 40), 0, 64'sd1 <<< 40, 64'sd7, 0);
               while (sb.expected_q.size() != 0) @(posedge clock);
               @(negedge clock);
               paused = 1;
               if (sb.busy) send_item(ACT_ABORT, 0, 0, 0, 0, 0);
            end
         end
      end

      wait_drained();
      if (sb.mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
